// File: hdl/acqps_pkg.sv
// acqps_pkg: register map and fixed widths of the acquisition peak search
`timescale 1ns / 1ps

package acqps_pkg;

   localparam int CSR_DATA_W  = 18;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLES_PER_CODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIN_COUNT        = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOPPLER_MIN_HZ   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOPPLER_STEP_HZ  = 2'd3;

   localparam int SPC_W   = 17;
   localparam int BINS_W  = 9;
   localparam int DMIN_W  = 18;
   localparam int STEP_W  = 14;
   localparam int TOTAL_W = 56;
   localparam int DEN_W   = SPC_W + BINS_W;
   localparam int DOP_W   = 21;

   localparam int DOP_HI = 1048575;
   localparam int DOP_LO = -1048576;

   localparam logic [SPC_W-1:0]  SPC_RESET  = 17'd4096;
   localparam logic [BINS_W-1:0] BINS_RESET = 9'd21;
   localparam logic signed [DMIN_W-1:0] DMIN_RESET = -18'sd10000;
   localparam logic [STEP_W-1:0] STEP_RESET = 14'd1000;

endpackage

// File: hdl/acquisition_peak_search_top.sv
// acquisition_peak_search_top: correlation peak search with running mean
`timescale 1ns / 1ps

// channel   dir  handshake             payload
// req       in   req_valid/req_ready   req_magnitude
// rsp       out  rsp_valid/rsp_ready   rsp_peak_value, rsp_peak_phase, rsp_peak_bin,
//                                      rsp_peak_doppler_hz, rsp_mean_value
// csr       in   csr_we                csr_index, csr_wdata
//
// one magnitude per cycle while a search runs
// the last sample of a search starts a restoring divider for the mean, then the
// result register is loaded; req_ready stays low from that last sample until the load
// the result sits in an output register; a new search starts while it waits
// if the previous result is still not taken the block holds before loading
// synchronous active-high reset restores register defaults and clears the search

module acquisition_peak_search_top #(
   parameter int MAX_SAMPLES = 65536,
   parameter int MAX_BINS    = 256,
   parameter int MAG_WIDTH   = 32
) (
   input  logic clock,
   input  logic reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_magnitude,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rsp_peak_value,
   output logic [15:0]        rsp_peak_phase,
   output logic [7:0]         rsp_peak_bin,
   output logic signed [20:0] rsp_peak_doppler_hz,
   output logic [31:0]        rsp_mean_value,

   input  logic                               csr_we,
   input  logic [acqps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [acqps_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import acqps_pkg::*;

   localparam int MW     = (MAG_WIDTH < 32) ? MAG_WIDTH : 32;
   localparam int SPC_HI = (MAX_SAMPLES > 131071) ? 131071 : MAX_SAMPLES;
   localparam int BIN_HI = (MAX_BINS > 511) ? 511 : MAX_BINS;
   localparam int PW     = $clog2(SPC_HI);
   localparam int BNW    = (BIN_HI > 1) ? $clog2(BIN_HI) : 1;
   localparam int PRW    = BNW + STEP_W;
   localparam int DSW    = (PRW + 2 > 22) ? PRW + 2 : 22;
   localparam int CNT_W  = $clog2(TOTAL_W);

   localparam logic [SPC_W-1:0]  SPC_MAX  = SPC_W'(SPC_HI);
   localparam logic [BINS_W-1:0] BINS_MAX = BINS_W'(BIN_HI);
   localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(TOTAL_W - 1);

   localparam logic [1:0] ST_RUN = 2'd0;
   localparam logic [1:0] ST_DIV = 2'd1;
   localparam logic [1:0] ST_OUT = 2'd2;

   // configuration
   logic [SPC_W-1:0]         spc_cfg_ff;
   logic [BINS_W-1:0]        bins_cfg_ff;
   logic signed [DMIN_W-1:0] dmin_cfg_ff;
   logic [STEP_W-1:0]        step_cfg_ff;

   // control and search state
   logic [1:0]         state_ff, state_in;
   logic [PW-1:0]      phase_ff, phase_in;
   logic [BNW-1:0]     bin_ff, bin_in;
   logic [MW-1:0]      best_value_ff, best_value_in;
   logic [PW-1:0]      best_phase_ff, best_phase_in;
   logic [BNW-1:0]     best_bin_ff, best_bin_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // result and divider datapath
   logic [MW-1:0]      res_value_ff, res_value_in;
   logic [PW-1:0]      res_phase_ff, res_phase_in;
   logic [BNW-1:0]     res_bin_ff, res_bin_in;
   logic [PRW-1:0]     dop_prod_ff, dop_prod_in;
   logic [TOTAL_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [DEN_W-1:0]   rem_ff, rem_in;

   logic [31:0]        rsp_peak_value_ff, rsp_peak_value_in;
   logic [15:0]        rsp_peak_phase_ff, rsp_peak_phase_in;
   logic [7:0]         rsp_peak_bin_ff, rsp_peak_bin_in;
   logic signed [20:0] rsp_dop_ff, rsp_dop_in;
   logic [31:0]        rsp_mean_ff, rsp_mean_in;

   logic [SPC_W-1:0]   spc_eff;
   logic [BINS_W-1:0]  bins_eff;
   logic [MW-1:0]      mag_eff;
   logic               take;
   logic               upd;
   logic               last_phase;
   logic               last_bin;
   logic [MW-1:0]      best_value_nx;
   logic [PW-1:0]      best_phase_nx;
   logic [BNW-1:0]     best_bin_nx;
   logic [TOTAL_W-1:0] total_sum;
   logic [DEN_W:0]     rem_sh;
   logic [DEN_W:0]     rem_diff;
   logic               rem_ge;
   logic signed [DSW-1:0] dop_sum;
   logic signed [DSW-1:0] dop_sat;
   logic               load_out;

   always_comb begin
      if (spc_cfg_ff == '0) begin
         spc_eff = SPC_W'(1);
      end else if (spc_cfg_ff > SPC_MAX) begin
         spc_eff = SPC_MAX;
      end else begin
         spc_eff = spc_cfg_ff;
      end
      if (bins_cfg_ff == '0) begin
         bins_eff = BINS_W'(1);
      end else if (bins_cfg_ff > BINS_MAX) begin
         bins_eff = BINS_MAX;
      end else begin
         bins_eff = bins_cfg_ff;
      end
   end

   assign req_ready = (state_ff == ST_RUN);
   assign take      = req_valid && req_ready;
   assign mag_eff   = MW'(req_magnitude);
   assign upd       = mag_eff > best_value_ff;

   assign best_value_nx = upd ? mag_eff : best_value_ff;
   assign best_phase_nx = upd ? phase_ff : best_phase_ff;
   assign best_bin_nx   = upd ? bin_ff : best_bin_ff;
   assign total_sum     = total_ff + TOTAL_W'(mag_eff);

   assign last_phase = SPC_W'(phase_ff) >= (spc_eff - SPC_W'(1));
   assign last_bin   = BINS_W'(bin_ff) >= (bins_eff - BINS_W'(1));

   // one restoring step per cycle
   assign rem_sh   = {rem_ff, num_ff[TOTAL_W-1]};
   assign rem_diff = rem_sh - {1'b0, den_ff};
   assign rem_ge   = rem_sh >= {1'b0, den_ff};

   always_comb begin
      dop_sum = DSW'(dmin_cfg_ff) + DSW'($signed({1'b0, dop_prod_ff}));
      if (dop_sum > DSW'(DOP_HI)) begin
         dop_sat = DSW'(DOP_HI);
      end else if (dop_sum < DSW'(DOP_LO)) begin
         dop_sat = DSW'(DOP_LO);
      end else begin
         dop_sat = dop_sum;
      end
   end

   assign load_out = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      bin_in        = bin_ff;
      best_value_in = best_value_ff;
      best_phase_in = best_phase_ff;
      best_bin_in   = best_bin_ff;
      total_in      = total_ff;
      cnt_in        = cnt_ff;
      res_value_in  = res_value_ff;
      res_phase_in  = res_phase_ff;
      res_bin_in    = res_bin_ff;
      dop_prod_in   = dop_prod_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      rem_in        = rem_ff;

      unique case (state_ff)
         ST_RUN: begin
            if (take) begin
               best_value_in = best_value_nx;
               best_phase_in = best_phase_nx;
               best_bin_in   = best_bin_nx;
               total_in      = total_sum;
               if (!last_phase) begin
                  phase_in = phase_ff + PW'(1);
               end else if (!last_bin) begin
                  phase_in = '0;
                  bin_in   = bin_ff + BNW'(1);
               end else begin
                  res_value_in  = best_value_nx;
                  res_phase_in  = best_phase_nx;
                  res_bin_in    = best_bin_nx;
                  num_in        = total_sum;
                  den_in        = DEN_W'(spc_eff) * DEN_W'(bins_eff);
                  rem_in        = '0;
                  cnt_in        = '0;
                  phase_in      = '0;
                  bin_in        = '0;
                  best_value_in = '0;
                  best_phase_in = '0;
                  best_bin_in   = '0;
                  total_in      = '0;
                  state_in      = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            dop_prod_in = PRW'(res_bin_ff) * PRW'(step_cfg_ff);
            rem_in      = rem_ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            num_in      = {num_ff[TOTAL_W-2:0], rem_ge};
            cnt_in      = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (load_out) begin
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_peak_value_in = rsp_peak_value_ff;
      rsp_peak_phase_in = rsp_peak_phase_ff;
      rsp_peak_bin_in   = rsp_peak_bin_ff;
      rsp_dop_in        = rsp_dop_ff;
      rsp_mean_in       = rsp_mean_ff;
      if (load_out) begin
         rsp_valid_in      = 1'b1;
         rsp_peak_value_in = 32'(res_value_ff);
         rsp_peak_phase_in = 16'(res_phase_ff);
         rsp_peak_bin_in   = 8'(res_bin_ff);
         rsp_dop_in        = DOP_W'(dop_sat);
         rsp_mean_in       = num_ff[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spc_cfg_ff  <= SPC_RESET;
         bins_cfg_ff <= BINS_RESET;
         dmin_cfg_ff <= DMIN_RESET;
         step_cfg_ff <= STEP_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SAMPLES_PER_CODE: spc_cfg_ff  <= csr_wdata[SPC_W-1:0];
            CSR_BIN_COUNT:        bins_cfg_ff <= csr_wdata[BINS_W-1:0];
            CSR_DOPPLER_MIN_HZ:   dmin_cfg_ff <= $signed(csr_wdata[DMIN_W-1:0]);
            CSR_DOPPLER_STEP_HZ:  step_cfg_ff <= csr_wdata[STEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RUN;
         phase_ff      <= '0;
         bin_ff        <= '0;
         best_value_ff <= '0;
         best_phase_ff <= '0;
         best_bin_ff   <= '0;
         total_ff      <= '0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         bin_ff        <= bin_in;
         best_value_ff <= best_value_in;
         best_phase_ff <= best_phase_in;
         best_bin_ff   <= best_bin_in;
         total_ff      <= total_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_value_ff      <= res_value_in;
      res_phase_ff      <= res_phase_in;
      res_bin_ff        <= res_bin_in;
      dop_prod_ff       <= dop_prod_in;
      num_ff            <= num_in;
      den_ff            <= den_in;
      rem_ff            <= rem_in;
      rsp_peak_value_ff <= rsp_peak_value_in;
      rsp_peak_phase_ff <= rsp_peak_phase_in;
      rsp_peak_bin_ff   <= rsp_peak_bin_in;
      rsp_dop_ff        <= rsp_dop_in;
      rsp_mean_ff       <= rsp_mean_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_peak_value      = rsp_peak_value_ff;
   assign rsp_peak_phase      = rsp_peak_phase_ff;
   assign rsp_peak_bin        = rsp_peak_bin_ff;
   assign rsp_peak_doppler_hz = rsp_dop_ff;
   assign rsp_mean_value      = rsp_mean_ff;

endmodule

// File: bench/testbench.sv
// testbench: self-checking bench for the acquisition peak search top level
`timescale 1ns / 1ps

module testbench;
   import acqps_pkg::*;

   localparam int SEARCH_MAX_SAMPLES = 65536;
   localparam int SEARCH_MAX_BINS    = 256;
   localparam int SETTLE_CYCLES      = 64;
   localparam int LONG_SEARCH_ITEMS  = 48;

   typedef struct {
      logic [31:0]        peak_value;
      logic [15:0]        peak_phase;
      logic [7:0]         peak_bin;
      logic signed [20:0] peak_doppler_hz;
      logic [31:0]        mean_value;
   } peak_result_type;

   logic clock = 1'b0;
   logic reset;

   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_magnitude;

   logic               rsp_valid;
   logic               rsp_ready;
   logic [31:0]        rsp_peak_value;
   logic [15:0]        rsp_peak_phase;
   logic [7:0]         rsp_peak_bin;
   logic signed [20:0] rsp_peak_doppler_hz;
   logic [31:0]        rsp_mean_value;

   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // register copies
   logic [SPC_W-1:0]         cfg_spc;
   logic [BINS_W-1:0]        cfg_bins;
   logic signed [DMIN_W-1:0] cfg_dmin;
   logic [STEP_W-1:0]        cfg_step;

   // search state
   logic [31:0]        best_mag;
   logic [15:0]        best_phase;
   logic [7:0]         best_bin;
   logic [15:0]        phase_pos;
   logic [7:0]         bin_pos;
   logic [TOTAL_W-1:0] mag_total;

   peak_result_type pending_peaks[$];
   peak_result_type oldest_peak;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count = 0;
   int items_sent = 0;
   int results_checked = 0;

   acquisition_peak_search_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_magnitude       (req_magnitude),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_peak_value      (rsp_peak_value),
      .rsp_peak_phase      (rsp_peak_phase),
      .rsp_peak_bin        (rsp_peak_bin),
      .rsp_peak_doppler_hz (rsp_peak_doppler_hz),
      .rsp_mean_value      (rsp_mean_value),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic clear_search();
      best_mag   = '0;
      best_phase = '0;
      best_bin   = '0;
      phase_pos  = '0;
      bin_pos    = '0;
      mag_total  = '0;
   endtask

   // one accepted magnitude through the search, queueing the result at the last sample
   task automatic advance_search(input logic [31:0] mag);
      int              spc_lim;
      int              bin_lim;
      longint          dop;
      logic [63:0]     quotient;
      peak_result_type peak;
      spc_lim = (cfg_spc == 0) ? 1 :
                (int'(cfg_spc) > SEARCH_MAX_SAMPLES) ? SEARCH_MAX_SAMPLES : int'(cfg_spc);
      bin_lim = (cfg_bins == 0) ? 1 :
                (int'(cfg_bins) > SEARCH_MAX_BINS) ? SEARCH_MAX_BINS : int'(cfg_bins);
      if (mag > best_mag) begin
         best_mag   = mag;
         best_phase = phase_pos;
         best_bin   = bin_pos;
      end
      mag_total = mag_total + TOTAL_W'(mag);
      if (int'(phase_pos) < spc_lim - 1) begin
         phase_pos = phase_pos + 16'd1;
      end else if (int'(bin_pos) < bin_lim - 1) begin
         phase_pos = '0;
         bin_pos   = bin_pos + 8'd1;
      end else begin
         dop = longint'(cfg_dmin) + longint'(best_bin) * longint'(cfg_step);
         if (dop > DOP_HI) dop = DOP_HI;
         if (dop < DOP_LO) dop = DOP_LO;
         quotient = 64'(mag_total) / (64'(spc_lim) * 64'(bin_lim));
         peak.peak_value      = best_mag;
         peak.peak_phase      = best_phase;
         peak.peak_bin        = best_bin;
         peak.peak_doppler_hz = dop[20:0];
         peak.mean_value      = quotient[31:0];
         pending_peaks.insert(pending_peaks.size(), peak);
         clear_search();
      end
   endtask

   task automatic push_magnitude(input logic [31:0] mag);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid     <= 1'b0;
         req_magnitude <= $urandom;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid     <= 1'b1;
      req_magnitude <= mag;
      do @(posedge clock); while (!req_ready);
      advance_search(mag);
      items_sent++;
   endtask

   // drain all results and let the divider finish before touching registers
   task automatic settle_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_peaks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_SAMPLES_PER_CODE: cfg_spc  = data[SPC_W-1:0];
         CSR_BIN_COUNT:        cfg_bins = data[BINS_W-1:0];
         CSR_DOPPLER_MIN_HZ:   cfg_dmin = data[DMIN_W-1:0];
         CSR_DOPPLER_STEP_HZ:  cfg_step = data[STEP_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_magnitude();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return 32'($urandom_range(0, 3));
         default: return $urandom;
      endcase
   endfunction

   task automatic finish_search();
      do push_magnitude(pick_magnitude()); while (phase_pos != 0 || bin_pos != 0);
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_peaks.size() == 0) begin
            $display("%0t: unexpected result transfer, expected none, actual peak %0d",
                     $time, rsp_peak_value);
            error_count++;
         end else begin
            oldest_peak = pending_peaks.pop_front();
            check_field("peak_value", oldest_peak.peak_value, rsp_peak_value);
            check_field("peak_phase", oldest_peak.peak_phase, rsp_peak_phase);
            check_field("peak_bin", oldest_peak.peak_bin, rsp_peak_bin);
            check_field("peak_doppler_hz", oldest_peak.peak_doppler_hz, rsp_peak_doppler_hz);
            check_field("mean_value", oldest_peak.mean_value, rsp_mean_value);
            results_checked++;
         end
      end
   end

   // reset doppler registers stay in force for this search
   task automatic test_all_zero();
      settle_block();
      write_register(CSR_SAMPLES_PER_CODE, 18'd2);
      write_register(CSR_BIN_COUNT, 18'd2);
      repeat (4) push_magnitude('0);
   endtask

   task automatic test_tie_first_wins();
      settle_block();
      write_register(CSR_SAMPLES_PER_CODE, 18'd3);
      write_register(CSR_BIN_COUNT, 18'd2);
      push_magnitude(32'd5);
      push_magnitude(32'd9);
      push_magnitude(32'd9);
      push_magnitude(32'd1);
      push_magnitude(32'd9);
      push_magnitude(32'd0);
   endtask

   // zero sizes clamp to one sample per search
   task automatic test_field_extremes();
      settle_block();
      write_register(CSR_SAMPLES_PER_CODE, 18'd0);
      write_register(CSR_BIN_COUNT, 18'd0);
      write_register(CSR_DOPPLER_MIN_HZ, 18'h20000);
      write_register(CSR_DOPPLER_STEP_HZ, 18'd0);
      push_magnitude(32'hFFFF_FFFF);
      settle_block();
      write_register(CSR_DOPPLER_MIN_HZ, 18'h1FFFF);
      push_magnitude(32'h0000_0000);
      settle_block();
      write_register(CSR_DOPPLER_STEP_HZ, 18'd16383);
      push_magnitude(32'hAAAA_AAAA);
      push_magnitude(32'h5555_5555);
   endtask

   task automatic test_mid_search_change();
      settle_block();
      write_register(CSR_SAMPLES_PER_CODE, 18'd4);
      write_register(CSR_BIN_COUNT, 18'd3);
      write_register(CSR_DOPPLER_MIN_HZ, 18'h3FF00);
      write_register(CSR_DOPPLER_STEP_HZ, 18'd250);
      repeat (6) push_magnitude(pick_magnitude());
      settle_block();
      write_register(CSR_SAMPLES_PER_CODE, 18'd2);
      repeat (3) push_magnitude(pick_magnitude());
      repeat (2) push_magnitude(pick_magnitude());
      settle_block();
      write_register(CSR_BIN_COUNT, 18'd1);
      finish_search();
   endtask

   // bin count above the limit clamps, peak in the last bin drives doppler into saturation
   task automatic test_doppler_saturation();
      settle_block();
      write_register(CSR_SAMPLES_PER_CODE, 18'd1);
      write_register(CSR_BIN_COUNT, 18'd511);
      write_register(CSR_DOPPLER_MIN_HZ, 18'h1FFFF);
      write_register(CSR_DOPPLER_STEP_HZ, 18'd16383);
      repeat (SEARCH_MAX_BINS - 1) push_magnitude(32'($urandom_range(0, 32'h7FFF_FFFF)));
      push_magnitude(32'hFFFF_FFFF);
   endtask

   // sample count above the limit clamps, then a smaller size ends the search past its end
   task automatic test_longest_search();
      settle_block();
      write_register(CSR_SAMPLES_PER_CODE, 18'h1FFFF);
      write_register(CSR_BIN_COUNT, 18'd1);
      write_register(CSR_DOPPLER_MIN_HZ, CSR_DATA_W'($urandom));
      repeat (LONG_SEARCH_ITEMS - 1) push_magnitude(32'($urandom_range(0, 65535)));
      push_magnitude(32'hFFFF_FFFE);
      settle_block();
      write_register(CSR_SAMPLES_PER_CODE, 18'd2);
      finish_search();
   endtask

   task automatic test_random_searches(input int item_budget);
      logic [CSR_DATA_W-1:0] spc_val;
      logic [CSR_DATA_W-1:0] bin_val;
      int                    start_count;
      start_count = items_sent;
      while (items_sent - start_count < item_budget) begin
         settle_block();
         if ($urandom_range(9) == 0) spc_val = '0;
         else if ($urandom_range(5) == 0) spc_val = CSR_DATA_W'($urandom_range(9, 40));
         else spc_val = CSR_DATA_W'($urandom_range(1, 6));
         bin_val = ($urandom_range(9) == 0) ? '0 : CSR_DATA_W'($urandom_range(1, 4));
         write_register(CSR_SAMPLES_PER_CODE, spc_val);
         write_register(CSR_BIN_COUNT, bin_val);
         if ($urandom_range(1) == 0) write_register(CSR_DOPPLER_MIN_HZ, CSR_DATA_W'($urandom));
         if ($urandom_range(1) == 0)
            write_register(CSR_DOPPLER_STEP_HZ, CSR_DATA_W'($urandom_range(0, 16383)));
         if ($urandom_range(7) == 0) begin
            repeat ($urandom_range(1, 6)) push_magnitude(pick_magnitude());
            settle_block();
            case ($urandom_range(3))
               0: write_register(CSR_SAMPLES_PER_CODE, CSR_DATA_W'($urandom_range(1, 6)));
               1: write_register(CSR_BIN_COUNT, CSR_DATA_W'($urandom_range(1, 4)));
               2: write_register(CSR_DOPPLER_MIN_HZ, CSR_DATA_W'($urandom));
               default: write_register(CSR_DOPPLER_STEP_HZ,
                                       CSR_DATA_W'($urandom_range(0, 16383)));
            endcase
         end
         finish_search();
      end
   endtask

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_magnitude <= '0;
      rsp_ready     <= 1'b0;
      csr_we        <= 1'b0;
      csr_index     <= '0;
      csr_wdata     <= '0;
      cfg_spc  = SPC_RESET;
      cfg_bins = BINS_RESET;
      cfg_dmin = DMIN_RESET;
      cfg_step = STEP_RESET;
      clear_search();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 8;
      recv_idle_pct = 82;
      test_all_zero();
      test_tie_first_wins();
      test_field_extremes();
      test_mid_search_change();
      test_random_searches(200);

      send_idle_pct = 82;
      recv_idle_pct = 8;
      test_doppler_saturation();
      test_random_searches(200);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_longest_search();
      test_random_searches(200);

      settle_block();
      repeat (100) @(posedge clock);
      $display("covered %0d magnitude transfers and %0d search results, one sample to 256 bins,",
               items_sent, results_checked);
      $display("with clamping, ties, doppler saturation and register changes part way through");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #(10_000_000);
      $display("timeout with %0d results still pending", pending_peaks.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
